// ===== hw/rtl/lru_asset_cache_defines.svh =====
// Assertion macros for the LRU asset cache.
// Included by the files that check themselves; needs no other file.
`ifndef LRU_ASSET_CACHE_DEFINES_SVH
`define LRU_ASSET_CACHE_DEFINES_SVH

`ifndef SYNTH
// check a property on every rising edge, off while reset is high
`define LAC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lru_asset_cache: assertion failed");
// check a property on every rising edge, reset included
`define LAC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lru_asset_cache: assertion failed");
`else
`define LAC_ASSERT(lbl, clk, rst, prop)
`define LAC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/lac_pkg.sv =====
// Shared sizes and constants for the LRU asset cache.
// No dependencies.
package lac_pkg;

   localparam int MAX_ENTRIES = 8;
   localparam int KEY_BITS    = 32;
   localparam int SLOT_BITS   = 3;
   localparam int RANK_BITS   = 3;
   localparam int CNT_BITS    = 4;
   localparam int LIMIT_BITS  = 4;
   localparam int SCAN_BITS   = 4;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd5;

   typedef logic [KEY_BITS-1:0]  key_type;
   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [RANK_BITS-1:0] rank_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

endpackage

// ===== hw/rtl/lru_asset_cache.sv =====
// LRU asset cache, top level: key memory, scan sequencer, recency update.
// Depends on lac_pkg and lru_asset_cache_defines.svh.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-----------------------------
//  request  | req_key, req_load_ok                   | start & !busy at rising edge
//  response | rsp_hit/found/slot/evicted/evicted_key | rsp_strobe, one cycle
//  csr      | csr_wr_data (cache_limit)              | csr_wr_en at rising edge
//
// A request runs from the accepting edge through the scan, the decide state and
// the strobe cycle: one key comparator walks the key memory one slot per cycle
// (8 reads, then the compare of the last read), the decide state applies the
// update, then the strobe cycle follows. busy is low again in the strobe
// cycle, so a new beat can be taken at its closing edge, not before that.
// Reset clears valid marks, ranks, count and the limit (back to 5).
// The receiver cannot stall.
`include "lru_asset_cache_defines.svh"

module lru_asset_cache
   import lac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic                  req_load_ok,
   input  logic                  csr_wr_en,
   input  logic [LIMIT_BITS-1:0] csr_wr_data,
   output logic                  rsp_strobe,
   output logic                  rsp_hit,
   output logic                  rsp_found,
   output logic [SLOT_BITS-1:0]  rsp_slot,
   output logic                  rsp_evicted,
   output logic [KEY_BITS-1:0]   rsp_evicted_key
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   localparam logic [SCAN_BITS-1:0] SCAN_LAST = SCAN_BITS'(MAX_ENTRIES);
   localparam logic [CNT_BITS-1:0]  CNT_MAX   = CNT_BITS'(MAX_ENTRIES);

   logic [1:0]            state_ff, state_in;
   logic [SCAN_BITS-1:0]  scan_ff, scan_in;
   logic [LIMIT_BITS-1:0] limit_ff;
   key_type               key_ff;
   logic                  load_ok_ff;

   key_type               entry_keys_mem [MAX_ENTRIES];
   key_type               rd_key_ff;
   slot_type              rd_slot_ff;
   logic                  rd_vld_ff;

   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   rank_type               rank_ff [MAX_ENTRIES];
   rank_type               rank_in [MAX_ENTRIES];
   cnt_type                count_ff, count_in;

   logic                  match_ff;
   slot_type              match_slot_ff;
   logic                  lru_have_ff;
   slot_type              lru_slot_ff;
   rank_type              lru_rank_ff;
   key_type               lru_key_ff;
   logic                  free_have_ff;
   slot_type              free_slot_ff;

   logic                  rsp_strobe_ff;
   logic                  rsp_hit_ff, rsp_found_ff, rsp_evicted_ff;
   slot_type              rsp_slot_ff;
   key_type               rsp_evicted_key_ff;

   logic                  accept;
   logic                  scan_rd;
   logic                  mem_wr;
   slot_type              mem_wr_slot;
   cnt_type               eff_limit;
   logic                  do_evict;
   slot_type              touch_slot;
   logic [RANK_BITS:0]    touch_thr;

   assign busy   = reset || (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign scan_rd = (state_ff == ST_SCAN) && (scan_ff != SCAN_LAST);

   // a limit of zero acts as one, above the depth acts as the depth
   always_comb begin
      if (limit_ff == '0) begin
         eff_limit = CNT_BITS'(1);
      end else if (CNT_BITS'(limit_ff) > CNT_MAX) begin
         eff_limit = CNT_MAX;
      end else begin
         eff_limit = CNT_BITS'(limit_ff);
      end
   end

   assign do_evict = (count_ff >= eff_limit);

   // sequencer
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               scan_in  = '0;
            end
         end
         ST_SCAN: begin
            if (scan_ff == SCAN_LAST) begin
               state_in = ST_DECIDE;
            end else begin
               scan_in = scan_ff + SCAN_BITS'(1);
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff     <= req_key;
         load_ok_ff <= req_load_ok;
      end
   end

   // key memory: one read port for the scan, one write port for the update
   always_ff @(posedge clock) begin
      if (scan_rd) begin
         rd_key_ff <= entry_keys_mem[scan_ff[SLOT_BITS-1:0]];
      end
      rd_slot_ff <= scan_ff[SLOT_BITS-1:0];
      if (mem_wr) begin
         entry_keys_mem[mem_wr_slot] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= scan_rd;
      end
   end

   // shared compare step: one slot per cycle, one read behind the scan
   always_ff @(posedge clock) begin
      if (accept) begin
         match_ff     <= 1'b0;
         lru_have_ff  <= 1'b0;
         free_have_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (valid_ff[rd_slot_ff]) begin
            if (!match_ff && (rd_key_ff == key_ff)) begin
               match_ff      <= 1'b1;
               match_slot_ff <= rd_slot_ff;
            end
            if (!lru_have_ff || (rank_ff[rd_slot_ff] > lru_rank_ff)) begin
               lru_have_ff <= 1'b1;
               lru_slot_ff <= rd_slot_ff;
               lru_rank_ff <= rank_ff[rd_slot_ff];
               lru_key_ff  <= rd_key_ff;
            end
         end else if (!free_have_ff) begin
            free_have_ff <= 1'b1;
            free_slot_ff <= rd_slot_ff;
         end
      end
   end

   // update: hit and evict age entries younger than the touched one,
   // insert ages every valid entry
   always_comb begin
      mem_wr      = 1'b0;
      mem_wr_slot = free_slot_ff;
      touch_slot  = free_slot_ff;
      touch_thr   = (RANK_BITS+1)'(MAX_ENTRIES);
      valid_in    = valid_ff;
      count_in    = count_ff;
      if (match_ff) begin
         touch_slot = match_slot_ff;
         touch_thr  = {1'b0, rank_ff[match_slot_ff]};
      end else if (do_evict) begin
         mem_wr      = (state_ff == ST_DECIDE) && load_ok_ff;
         mem_wr_slot = lru_slot_ff;
         touch_slot  = lru_slot_ff;
         touch_thr   = {1'b0, lru_rank_ff};
      end else begin
         mem_wr = (state_ff == ST_DECIDE) && load_ok_ff;
         if (mem_wr) begin
            valid_in[free_slot_ff] = 1'b1;
            count_in = count_ff + CNT_BITS'(1);
         end
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (valid_ff[i] && ({1'b0, rank_ff[i]} < touch_thr)) begin
            rank_in[i] = rank_ff[i] + RANK_BITS'(1);
         end
      end
      rank_in[touch_slot] = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if ((state_ff == ST_DECIDE) && (match_ff || load_ok_ff)) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_DECIDE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         rsp_hit_ff         <= match_ff;
         rsp_found_ff       <= match_ff || load_ok_ff;
         rsp_evicted_ff     <= !match_ff && load_ok_ff && do_evict;
         rsp_slot_ff        <= '0;
         rsp_evicted_key_ff <= '0;
         if (match_ff) begin
            rsp_slot_ff <= match_slot_ff;
         end else if (load_ok_ff) begin
            rsp_slot_ff <= do_evict ? lru_slot_ff : free_slot_ff;
            if (do_evict) begin
               rsp_evicted_key_ff <= lru_key_ff;
            end
         end
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

   `LAC_ASSERT(a_count_matches_valid, clock, reset, (CNT_BITS'($countones(valid_ff)) == count_ff))
   `LAC_ASSERT(a_strobe_frees_block, clock, reset, rsp_strobe |-> (state_ff == ST_IDLE))
   `LAC_ASSERT(a_evict_is_load, clock, reset, (rsp_strobe && rsp_evicted) |-> (rsp_found && !rsp_hit))
   `LAC_ASSERT(a_accept_starts_scan, clock, reset, accept |=> ((state_ff == ST_SCAN) && (scan_ff == '0)))

endmodule
